>>> hw/rtl/bitmap_page_frame_allocator_unit_defines.svh
// Assertion macros for the bitmap page frame allocator.
// Needs i_clk and i_rst_n in the scope of each use; no other dependencies.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BPFA_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bpfa assertion failed");
`define BPFA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error("bpfa assertion failed");
`else
`define BPFA_ASSERT(name, prop)
`define BPFA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> hw/rtl/bpfa_pkg.sv
// Package for the bitmap page frame allocator: sizes, mode codes and
// the request and result types. No dependencies.
package bpfa_pkg;

    localparam int unsigned NUM_PAGES      = 65536;
    localparam int unsigned RESERVED_PAGES = 1024;
    localparam int unsigned PAGE_LIMIT     = 65536;
    localparam int unsigned WORD_BITS      = 32;
    localparam int unsigned NUM_WORDS      = NUM_PAGES / WORD_BITS;
    localparam int unsigned WADDR_W        = $clog2(NUM_WORDS);
    localparam int unsigned BIT_W          = $clog2(WORD_BITS);
    localparam int unsigned CNT_W          = 17;
    localparam int unsigned IDX_W          = 16;

    localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(65536);
    localparam logic [CNT_W-1:0] TOTAL_CAP =
        CNT_W'((NUM_PAGES < PAGE_LIMIT) ? NUM_PAGES : PAGE_LIMIT);
    localparam logic [CNT_W-1:0] RES_RESET =
        CNT_W'((RESERVED_PAGES < TOTAL_CAP) ? RESERVED_PAGES : TOTAL_CAP);

    localparam logic [1:0] MODE_ALLOC_ONE = 2'd0;
    localparam logic [1:0] MODE_ALLOC_RUN = 2'd1;
    localparam logic [1:0] MODE_FREE      = 2'd2;
    localparam logic [1:0] MODE_RESTART   = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] page_index;
        logic [CNT_W-1:0] count;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] page_index_out;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] used_count;
    } t_res;

endpackage

>>> hw/rtl/bitmap_page_frame_allocator_unit.sv
// An alloc request scans up to 2048 words of 32 pages for a free run.
// One request at a time; busy drops in the o_done cycle.
// Reset: synchronous; busy stays high while the map is rebuilt, with no result.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_unit_defines.svh.
`include "bitmap_page_frame_allocator_unit_defines.svh"

module bitmap_page_frame_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bpfa_pkg::t_req               i_req,
    output logic                         o_done,
    output bpfa_pkg::t_res               o_res,
    input  logic                         i_cfg_we,
    input  logic [bpfa_pkg::CNT_W-1:0]   i_cfg_wdata
);

    localparam int unsigned WA = bpfa_pkg::WADDR_W;
    localparam int unsigned CW = bpfa_pkg::CNT_W;
    localparam int unsigned BW = bpfa_pkg::BIT_W;
    localparam int unsigned NB = bpfa_pkg::WORD_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_INIT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [WA-1:0] LAST_WORD = WA'(bpfa_pkg::NUM_WORDS - 1);

    function automatic logic [NB-1:0] range_mask(
        input logic [WA-1:0] w,
        input logic [CW-1:0] lo,
        input logic [CW-1:0] hi
    );
        logic [NB-1:0] m;
        logic [CW-1:0] pg;
        for (int j = 0; j < NB; j++) begin
            pg   = CW'({w, BW'(j)});
            m[j] = (pg >= lo) && (pg < hi);
        end
        return m;
    endfunction

    logic [NB-1:0] mem [bpfa_pkg::NUM_WORDS];
    logic [NB-1:0] r_rdata;
    logic          mem_re;
    logic          mem_we;
    logic [WA-1:0] mem_raddr;
    logic [WA-1:0] mem_waddr;
    logic [NB-1:0] mem_wdata;

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_cfg, n_cfg;
    logic [CW-1:0]                 r_total, n_total;
    logic [CW-1:0]                 r_free, n_free;
    logic [CW-1:0]                 r_used, n_used;
    logic [CW-1:0]                 r_lo, n_lo;
    logic [CW-1:0]                 r_hi, n_hi;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_carry, n_carry;
    logic [WA-1:0]                 r_rd_w, n_rd_w;
    logic [WA-1:0]                 r_end_w, n_end_w;
    logic [WA-1:0]                 r_dw, n_dw;
    logic                          r_rd_on, n_rd_on;
    logic                          r_rvld, n_rvld;
    logic                          r_set, n_set;
    logic                          r_ok, n_ok;
    logic                          r_reply, n_reply;
    logic [bpfa_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic                          r_done, n_done;
    bpfa_pkg::t_res                r_res, n_res;

    // scan datapath
    logic [NB-1:0] scan_free;
    logic [5:0]    s_last [NB];
    logic [CW-1:0] s_run  [NB];
    logic          scan_hit;
    logic [BW-1:0] scan_bit;
    logic [CW-1:0] scan_end_pg;
    logic [CW-1:0] scan_first;

    // sweep datapath
    logic [NB-1:0] sw_mask;
    logic [NB-1:0] sw_new;
    logic [NB-1:0] sw_chg;
    logic [CW-1:0] sw_pc;
    logic [NB-1:0] init_word;

    // request decode
    logic [CW-1:0] req_cnt;
    logic [CW:0]   free_end_raw;
    logic [CW-1:0] free_hi;
    logic [CW-1:0] free_last;
    logic [CW-1:0] total_last;
    logic [CW-1:0] rs_total;
    logic [CW-1:0] rs_res;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_comb begin
        scan_free = ~r_rdata & range_mask(r_dw, '0, r_total);
        for (int j = 0; j < NB; j++) begin
            s_last[j] = '0;
            for (int k = 0; k < NB; k++) begin
                if (k <= j && !scan_free[k]) begin
                    s_last[j] = 6'(k + 1);
                end
            end
            if (s_last[j] == '0) begin
                s_run[j] = r_carry + CW'(j + 1);
            end else begin
                s_run[j] = CW'(j + 1) - CW'(s_last[j]);
            end
        end
        scan_hit = 1'b0;
        scan_bit = '0;
        for (int j = NB - 1; j >= 0; j--) begin
            if (scan_free[j] && (s_run[j] >= r_cnt)) begin
                scan_hit = 1'b1;
                scan_bit = BW'(j);
            end
        end
        scan_end_pg = CW'({r_dw, scan_bit}) + CW'(1);
        scan_first  = scan_end_pg - r_cnt;
    end

    always_comb begin
        sw_mask   = range_mask(r_dw, r_lo, r_hi);
        sw_new    = r_set ? (r_rdata | sw_mask) : (r_rdata & ~sw_mask);
        sw_chg    = r_set ? (~r_rdata & sw_mask) : (r_rdata & sw_mask);
        sw_pc     = CW'($countones(sw_chg));
        init_word = range_mask(r_rd_w, '0, r_hi);
    end

    always_comb begin
        req_cnt      = (i_req.mode == bpfa_pkg::MODE_ALLOC_ONE) ? CW'(1) : i_req.count;
        free_end_raw = CW'(i_req.page_index) + {1'b0, i_req.count};
        free_hi      = (free_end_raw > {1'b0, r_total}) ? r_total : free_end_raw[CW-1:0];
        free_last    = free_hi - CW'(1);
        total_last   = r_total - CW'(1);
        rs_total     = (r_cfg > bpfa_pkg::TOTAL_CAP) ? bpfa_pkg::TOTAL_CAP : r_cfg;
        rs_res       = (rs_total < CW'(bpfa_pkg::RESERVED_PAGES)) ?
                       rs_total : CW'(bpfa_pkg::RESERVED_PAGES);
    end

    always_comb begin
        n_state   = r_state;
        n_cfg     = i_cfg_we ? i_cfg_wdata : r_cfg;
        n_total   = r_total;
        n_free    = r_free;
        n_used    = r_used;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_cnt     = r_cnt;
        n_carry   = r_carry;
        n_rd_w    = r_rd_w;
        n_end_w   = r_end_w;
        n_dw      = r_dw;
        n_rd_on   = r_rd_on;
        n_rvld    = r_rvld;
        n_set     = r_set;
        n_ok      = r_ok;
        n_reply   = r_reply;
        n_idx     = r_idx;
        n_done    = 1'b0;
        n_res     = r_res;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = r_rd_w;
        mem_waddr = r_dw;
        mem_wdata = sw_new;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_ok  = 1'b1;
                    n_idx = '0;
                    n_rvld = 1'b0;
                    case (i_req.mode)
                        bpfa_pkg::MODE_ALLOC_ONE, bpfa_pkg::MODE_ALLOC_RUN: begin
                            if (req_cnt != '0 && req_cnt <= r_free && req_cnt <= r_total) begin
                                n_state = ST_SCAN;
                                n_cnt   = req_cnt;
                                n_carry = '0;
                                n_rd_w  = '0;
                                n_end_w = total_last[WA+BW-1:BW];
                                n_rd_on = 1'b1;
                            end else begin
                                n_ok    = 1'b0;
                                n_state = ST_DONE;
                            end
                        end
                        bpfa_pkg::MODE_FREE: begin
                            if (free_hi > CW'(i_req.page_index)) begin
                                n_state = ST_SWEEP;
                                n_set   = 1'b0;
                                n_lo    = CW'(i_req.page_index);
                                n_hi    = free_hi;
                                n_rd_w  = i_req.page_index[WA+BW-1:BW];
                                n_end_w = free_last[WA+BW-1:BW];
                                n_rd_on = 1'b1;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        bpfa_pkg::MODE_RESTART: begin
                            n_state = ST_INIT;
                            n_total = rs_total;
                            n_hi    = rs_res;
                            n_rd_w  = '0;
                            n_rd_on = 1'b0;
                            n_reply = 1'b1;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN, ST_SWEEP: begin
                if (r_rd_on) begin
                    mem_re = 1'b1;
                    n_dw   = r_rd_w;
                    n_rvld = 1'b1;
                    if (r_rd_w == r_end_w) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_rd_w = r_rd_w + WA'(1);
                    end
                end else begin
                    n_rvld = 1'b0;
                end
                if (r_rvld && r_state == ST_SCAN) begin
                    if (scan_hit) begin
                        n_state = ST_SWEEP;
                        n_set   = 1'b1;
                        n_lo    = scan_first;
                        n_hi    = scan_end_pg;
                        n_idx   = scan_first[bpfa_pkg::IDX_W-1:0];
                        n_rd_w  = scan_first[WA+BW-1:BW];
                        n_end_w = r_dw;
                        n_rd_on = 1'b1;
                        n_rvld  = 1'b0;
                    end else if (r_dw == r_end_w) begin
                        n_state = ST_DONE;
                        n_ok    = 1'b0;
                        n_idx   = '0;
                        n_rvld  = 1'b0;
                    end else begin
                        n_carry = s_run[NB-1];
                    end
                end else if (r_rvld) begin
                    mem_we = 1'b1;
                    if (r_set) begin
                        n_free = r_free - sw_pc;
                        n_used = r_used + sw_pc;
                    end else begin
                        n_free = r_free + sw_pc;
                        n_used = r_used - sw_pc;
                    end
                    if (r_dw == r_end_w) begin
                        n_state = ST_DONE;
                        n_rvld  = 1'b0;
                    end
                end
            end
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_rd_w;
                mem_wdata = init_word;
                if (r_rd_w == LAST_WORD) begin
                    n_free  = r_total - r_hi;
                    n_used  = r_hi;
                    n_ok    = 1'b1;
                    n_idx   = '0;
                    // the pass after reset ends silently
                    n_state = r_reply ? ST_DONE : ST_IDLE;
                end else begin
                    n_rd_w = r_rd_w + WA'(1);
                end
            end
            ST_DONE: begin
                n_done  = 1'b1;
                n_res   = '{ok: r_ok, page_index_out: r_idx,
                            free_count: r_free, used_count: r_used};
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cfg   <= bpfa_pkg::CFG_RESET;
            r_total <= bpfa_pkg::TOTAL_CAP;
            r_hi    <= bpfa_pkg::RES_RESET;
            r_rd_w  <= '0;
            r_rd_on <= 1'b0;
            r_rvld  <= 1'b0;
            r_reply <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cfg   <= n_cfg;
            r_total <= n_total;
            r_hi    <= n_hi;
            r_rd_w  <= n_rd_w;
            r_rd_on <= n_rd_on;
            r_rvld  <= n_rvld;
            r_reply <= n_reply;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free  <= n_free;
        r_used  <= n_used;
        r_lo    <= n_lo;
        r_cnt   <= n_cnt;
        r_carry <= n_carry;
        r_end_w <= n_end_w;
        r_dw    <= n_dw;
        r_set   <= n_set;
        r_ok    <= n_ok;
        r_idx   <= n_idx;
        r_res   <= n_res;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    `BPFA_ASSERT(a_counts_sum, (r_state == ST_IDLE) |-> ((r_free + r_used) == r_total))
    `BPFA_ASSERT(a_done_idle, r_done |-> (r_state == ST_IDLE))
    `BPFA_ASSERT(a_sweep_range, (r_state == ST_SWEEP) |-> (r_hi > r_lo))
    `BPFA_ASSERT_NEXT(a_accept_busy, (start && !busy), busy)

endmodule
